### rtl/shrp_pkg.sv
// Shared types and constants for the 3x3 RGB sharpen filter.
package shrp_pkg;

  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 13;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_t;

  // Red sits in the lowest byte, matching the stream data layout.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic emit;
    logic edge_col;
    logic top;
    logic bottom;
    logic left_clamp;
    logic last;
  } cmd_flags_t;

endpackage

### rtl/shrp_front.sv
// Front end: frame position tracking, item classification and configuration.
module shrp_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int XW = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [shrp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [shrp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  shrp_pkg::req_type_t             in_req,
  input  shrp_pkg::rgb_t                  in_pix,
  input  logic                            q_full,
  output logic                            push,
  output logic [XW-1:0]                   push_addr,
  output shrp_pkg::cmd_flags_t            push_flags,
  output shrp_pkg::rgb_t                  push_pix
);
  import shrp_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 2);

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;

  logic [WW-1:0] col_inc;
  logic          col_wrap;
  logic [YW-1:0] height_ext;
  logic [YW-1:0] height_plus1;
  logic          rows_done;
  logic          item_ok;
  logic          edge_emit;
  logic          centre_emit;
  logic [31:0]   wr_width;
  logic [31:0]   wr_height;
  logic [31:0]   width_clamped;
  logic [31:0]   height_clamped;

  always_comb begin
    in_ready     = !q_full;
    col_inc      = WW'(col) + WW'(1);
    col_wrap     = col_inc >= width_eff;
    height_ext   = YW'(height_eff);
    height_plus1 = height_ext + YW'(1);
    rows_done    = row >= height_ext;
    item_ok      = (in_req == REQ_PIXEL) ? !rows_done : rows_done;
    push         = in_valid && in_ready && item_ok;
    edge_emit    = (col == '0) && (row >= YW'(2));
    centre_emit  = (col != '0) && (row != '0);

    push_addr             = col;
    push_pix              = (in_req == REQ_PIXEL) ? in_pix : '0;
    push_flags.emit       = edge_emit || centre_emit;
    push_flags.edge_col   = edge_emit;
    push_flags.top        = edge_emit ? (row == YW'(2)) : (row == YW'(1));
    push_flags.bottom     = edge_emit ? (row >= height_plus1) : rows_done;
    push_flags.left_clamp = edge_emit ? (width_eff == WW'(1)) : (col == XW'(1));
    push_flags.last       = edge_emit && (row == height_plus1);

    wr_width  = 32'(cfg_data[IMAGE_WIDTH_W-1:0]);
    wr_height = 32'(cfg_data[IMAGE_HEIGHT_W-1:0]);
    if (wr_width == 32'd0) begin
      width_clamped = 32'd1;
    end else if (wr_width > 32'(MAX_WIDTH)) begin
      width_clamped = 32'(MAX_WIDTH);
    end else begin
      width_clamped = wr_width;
    end
    if (wr_height == 32'd0) begin
      height_clamped = 32'd1;
    end else if (wr_height > 32'(MAX_HEIGHT)) begin
      height_clamped = 32'(MAX_HEIGHT);
    end else begin
      height_clamped = wr_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      width_eff  <= WW'(1);
      height_eff <= HW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_eff <= width_clamped[WW-1:0];
          col       <= '0;
          row       <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_eff <= height_clamped[HW-1:0];
          col        <= '0;
          row        <= '0;
        end
        default: begin
        end
      endcase
    end else if (push) begin
      if (push_flags.last) begin
        col <= '0;
        row <= '0;
      end else if (col_wrap) begin
        col <= '0;
        row <= row + YW'(1);
      end else begin
        col <= col_inc[XW-1:0];
      end
    end
  end

endmodule

### rtl/shrp_queue.sv
// Two-entry command queue between the front end and the back end.
module shrp_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data,
  input  logic              pop
);
  localparam int DEPTH = 2;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot [DEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [CW-1:0]     count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/shrp_back.sv
// Back end: line store memory, 3x3 window, sharpen arithmetic and output register.
module shrp_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int XW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  logic [XW-1:0]        q_addr,
  input  shrp_pkg::cmd_flags_t q_flags,
  input  shrp_pkg::rgb_t       q_pix,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output shrp_pkg::rgb_t       out_pix,
  output logic                 out_last
);
  import shrp_pkg::*;

  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_entry_t;

  function automatic logic [7:0] sharpen(input logic [7:0] c, input logic [7:0] u,
                                         input logic [7:0] d, input logic [7:0] l,
                                         input logic [7:0] r);
    logic [11:0] pos;
    logic [11:0] neg;
    logic [11:0] diff;
    pos  = {2'b00, c, 2'b00} + {4'b0000, c};
    neg  = {4'b0000, u} + {4'b0000, d} + {4'b0000, l} + {4'b0000, r};
    diff = pos - neg;
    if (neg > pos) begin
      return 8'd0;
    end else if (diff > 12'd255) begin
      return 8'd255;
    end else begin
      return diff[7:0];
    end
  endfunction

  line_entry_t line_mem [MAX_WIDTH];
  line_entry_t rd_data;
  line_entry_t fwd_data;
  logic        fwd_hit;

  logic        b_valid;
  logic [XW-1:0] b_addr;
  cmd_flags_t  b_flags;
  rgb_t        b_pix;

  rgb_t        win_c [3];
  rgb_t        left_mid;

  line_entry_t entry;
  line_entry_t wr_data;
  rgb_t        px_c;
  rgb_t        px_u;
  rgb_t        px_d;
  rgb_t        px_l;
  rgb_t        px_r;
  rgb_t        result;
  logic        out_free;
  logic        b_adv;

  always_comb begin
    entry          = fwd_hit ? fwd_data : rd_data;
    wr_data.upper  = entry.middle;
    wr_data.middle = b_pix;

    out_free = !out_valid || out_ready;
    b_adv    = b_valid && (!b_flags.emit || out_free);
    q_pop    = q_valid && (!b_valid || b_adv);

    px_c = win_c[1];
    px_u = b_flags.top ? win_c[1] : win_c[0];
    px_d = b_flags.bottom ? win_c[1] : win_c[2];
    px_l = b_flags.left_clamp ? win_c[1] : left_mid;
    px_r = b_flags.edge_col ? win_c[1] : entry.middle;

    result.red   = sharpen(px_c.red, px_u.red, px_d.red, px_l.red, px_r.red);
    result.green = sharpen(px_c.green, px_u.green, px_d.green, px_l.green, px_r.green);
    result.blue  = sharpen(px_c.blue, px_u.blue, px_d.blue, px_l.blue, px_r.blue);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data <= line_mem[q_addr];
    end
    if (b_adv) begin
      line_mem[b_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_addr   <= q_addr;
      b_flags  <= q_flags;
      b_pix    <= q_pix;
      fwd_data <= wr_data;
    end
    if (b_adv) begin
      left_mid <= win_c[1];
      win_c[0] <= entry.upper;
      win_c[1] <= entry.middle;
      win_c[2] <= b_pix;
    end
    if (b_adv && b_flags.emit && out_free) begin
      out_pix  <= result;
      out_last <= b_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
        fwd_hit <= b_adv && (b_addr == q_addr);
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv && b_flags.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/sharpen_3x3_rgb_filter.sv
// Top level of the streaming 3x3 sharpen filter for RGB888 frames.
//
//   Channel   Direction  Transaction carries
//   s_axis    in         one pixel (tuser 0) or one drain request (tuser 1)
//   m_axis    out        one sharpened pixel, tlast on the final pixel of the frame
//   cfg       in         one register write: image width (0) or image height (1)
//
// One transaction is taken per clock when the result side keeps up. A pixel's
// result comes out after the input transaction one line plus one pixel later,
// and from then passes through the command queue, the line store read and the
// output register. Drain transactions flush the last line and a pixel.
// Reset is synchronous; the line store memory holds no reset and needs no pass.
// A stall on m_axis fills the two-entry queue before s_axis_tready drops.
module sharpen_3x3_rgb_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // red_in, green_in, blue_in
  input  logic [0:0]                      s_axis_tuser,  // req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // red_out, green_out, blue_out
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [shrp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [shrp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import shrp_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW = XW + $bits(cmd_flags_t) + $bits(rgb_t);

  logic        push;
  logic [XW-1:0] push_addr;
  cmd_flags_t  push_flags;
  rgb_t        push_pix;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic [QW-1:0] q_head;
  logic [XW-1:0] q_addr;
  cmd_flags_t  q_flags;
  rgb_t        q_pix;
  rgb_t        in_pix;
  rgb_t        out_pix;
  req_type_t   in_req;

  assign in_pix       = rgb_t'(s_axis_tdata);
  assign in_req       = req_type_t'(s_axis_tuser[0]);
  assign m_axis_tdata = out_pix;
  assign {q_addr, q_flags, q_pix} = q_head;

  shrp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_req     (in_req),
    .in_pix     (in_pix),
    .q_full     (q_full),
    .push       (push),
    .push_addr  (push_addr),
    .push_flags (push_flags),
    .push_pix   (push_pix)
  );

  shrp_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_addr, push_flags, push_pix}),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_head),
    .pop        (q_pop)
  );

  shrp_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .XW        (XW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_addr    (q_addr),
    .q_flags   (q_flags),
    .q_pix     (q_pix),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pix   (out_pix),
    .out_last  (m_axis_tlast)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the streaming 3x3 RGB sharpen filter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import shrp_pkg::*;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned MAX_H = 4096;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned TALL_PIXELS = 40;

  typedef struct packed {
    rgb_t px;
    logic last;
  } sharp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sharpen_3x3_rgb_filter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [IMAGE_WIDTH_W-1:0] width_reg = 1;
  logic [IMAGE_HEIGHT_W-1:0] height_reg = 1;
  rgb_t upper_row_mem [MAX_W];
  rgb_t middle_row_mem [MAX_W];
  rgb_t sharp_win [3][3];
  int unsigned in_col = 0;
  int unsigned in_row = 0;
  int unsigned out_pos = 0;
  sharp_result_t expected_q [$];
  int unsigned live_items = 0;

  int mismatch_count = 0;
  int unsigned results_seen = 0;
  int src_calm = 0;
  int sink_calm = 0;
  int sink_stall = 0;
  int unsigned idle_cycles = 0;

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      upper_row_mem[i] = '0;
      middle_row_mem[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sharp_win[i][j] = '0;
      end
    end
  end

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned frame_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [7:0] sharpen_chan(logic [7:0] c, logic [7:0] u, logic [7:0] d,
                                              logic [7:0] l, logic [7:0] r);
    int s;
    s = 5 * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return s[7:0];
  endfunction

  function automatic rgb_t sharpen_at(int cc, int unsigned row, int unsigned col,
                                      int unsigned w, int unsigned h);
    int ur, dr, lc, rc;
    rgb_t c, u, d, l, r, o;
    ur = (row == 0) ? 1 : 0;
    dr = (row + 1 >= h) ? 1 : 2;
    lc = (col == 0) ? cc : cc - 1;
    rc = (col + 1 >= w) ? cc : cc + 1;
    c = sharp_win[1][cc];
    u = sharp_win[ur][cc];
    d = sharp_win[dr][cc];
    l = sharp_win[1][lc];
    r = sharp_win[1][rc];
    o.red = sharpen_chan(c.red, u.red, d.red, l.red, r.red);
    o.green = sharpen_chan(c.green, u.green, d.green, l.green, r.green);
    o.blue = sharpen_chan(c.blue, u.blue, d.blue, l.blue, r.blue);
    return o;
  endfunction

  task automatic restart_counts();
    in_col = 0;
    in_row = 0;
    out_pos = 0;
  endtask

  task automatic predict_sharpen(req_type_t kind, rgb_t px);
    int unsigned w, h, total, x, y, xi;
    rgb_t pix;
    bit hit;
    sharp_result_t res;
    w = frame_dim(width_reg, MAX_W);
    h = frame_dim(height_reg, MAX_H);
    total = w * h;
    x = in_col;
    y = in_row;
    pix = '0;
    hit = 1'b0;
    res = '0;
    if (kind == REQ_PIXEL) begin
      if (y >= h) return;
      pix = px;
    end else if (y < h || out_pos >= total) begin
      return;
    end
    live_items++;
    // The right-edge centre of the previous line leaves before the window shifts.
    if (x == 0 && y >= 2) begin
      res.px = sharpen_at(2, y - 2, w - 1, w, h);
      hit = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      sharp_win[i][0] = sharp_win[i][1];
      sharp_win[i][1] = sharp_win[i][2];
    end
    xi = (x >= MAX_W) ? MAX_W - 1 : x;
    sharp_win[0][2] = upper_row_mem[xi];
    sharp_win[1][2] = middle_row_mem[xi];
    sharp_win[2][2] = pix;
    upper_row_mem[xi] = middle_row_mem[xi];
    middle_row_mem[xi] = pix;
    if (x >= 1 && y >= 1) begin
      res.px = sharpen_at(1, y - 1, x - 1, w, h);
      hit = 1'b1;
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
    end
    in_col = x;
    in_row = y;
    if (hit) begin
      res.last = (out_pos + 1 >= total);
      out_pos++;
      expected_q.push_back(res);
      if (res.last) restart_counts();
    end
  endtask

  task automatic flag_mismatch(string msg);
    if (mismatch_count < 40) $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  function automatic rgb_t random_pixel();
    rgb_t p;
    p = rgb_t'($urandom());
    if ($urandom_range(0, 9) == 0) p.red = {8{p.red[0]}};
    if ($urandom_range(0, 9) == 0) p.green = {8{p.green[0]}};
    if ($urandom_range(0, 9) == 0) p.blue = {8{p.blue[0]}};
    return p;
  endfunction

  task automatic send_item(req_type_t kind, rgb_t px);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_sharpen(kind, px);
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val[IMAGE_WIDTH_W-1:0];
    else height_reg = val[IMAGE_HEIGHT_W-1:0];
    restart_counts();
    @(posedge clk);
  endtask

  // A full frame needs one drain per pixel of lag, that is one line plus one.
  task automatic stream_frame(int unsigned w, int unsigned h, bit noisy);
    for (int unsigned p = 0; p < w * h; p++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_item(REQ_DRAIN, random_pixel());
      send_item(REQ_PIXEL, random_pixel());
    end
    for (int unsigned k = 0; k <= w; k++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_item(REQ_PIXEL, random_pixel());
      send_item(REQ_DRAIN, random_pixel());
    end
  endtask

  task automatic test_reset_defaults();
    stream_frame(1, 1, 1'b0);
  endtask

  task automatic test_corner_values();
    rgb_t corner_px [9];
    corner_px = '{24'h000000, 24'hFFFFFF, 24'h000000,
                  24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                  24'h00FF00, 24'hAA55AA, 24'h0F80F0};
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(REQ_DRAIN, 24'hFFFFFF);
      send_item(REQ_PIXEL, corner_px[i]);
    end
    send_item(REQ_PIXEL, 24'h123456);
    for (int k = 0; k < 4; k++) send_item(REQ_DRAIN, random_pixel());
  endtask

  task automatic test_frame_restart();
    settle();
    // Bits above the width register are dropped, leaving a width of two.
    write_reg(REG_IMAGE_WIDTH, 13'h1802);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    for (int i = 0; i < 3; i++) send_item(REQ_PIXEL, random_pixel());
    settle();
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    stream_frame(2, 2, 1'b0);
    stream_frame(2, 2, 1'b0);
  endtask

  task automatic test_zero_sizes();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    send_item(REQ_DRAIN, random_pixel());
    stream_frame(1, 1, 1'b0);
  endtask

  // The first result needs the second pixel of the second line of a full-width frame.
  task automatic test_width_clamp();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    for (int unsigned p = 0; p < MAX_W + 2; p++) send_item(REQ_PIXEL, random_pixel());
  endtask

  task automatic test_tallest_frame();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    for (int unsigned p = 0; p < TALL_PIXELS; p++) send_item(REQ_PIXEL, random_pixel());
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h, n;
    int r;
    bit first;
    start = live_items;
    first = 1'b1;
    w = 1;
    h = 1;
    while (live_items - start < RANDOM_ITEMS) begin
      if (first || $urandom_range(0, 9) < 6) begin
        first = 1'b0;
        settle();
        r = $urandom_range(0, 99);
        if (r < 70) w = $urandom_range(1, 6);
        else if (r < 95) w = $urandom_range(7, 32);
        else w = $urandom_range(33, 120);
        h = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w | ($urandom_range(0, 3) << 11)));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        n = $urandom_range(w * h - 1, 0);
        for (int unsigned p = 0; p < n; p++) begin
          if ($urandom_range(0, 7) == 0) send_item(REQ_DRAIN, random_pixel());
          send_item(REQ_PIXEL, random_pixel());
        end
        settle();
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      end else begin
        stream_frame(w, h, r < 4);
      end
    end
  endtask

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("result with no pending expectation");
      end else begin
        sharp_result_t want;
        rgb_t got_px;
        want = expected_q.pop_front();
        got_px = m_axis_tdata;
        if (got_px.red !== want.px.red)
          flag_mismatch($sformatf("red got %0d want %0d", got_px.red, want.px.red));
        if (got_px.green !== want.px.green)
          flag_mismatch($sformatf("green got %0d want %0d", got_px.green, want.px.green));
        if (got_px.blue !== want.px.blue)
          flag_mismatch($sformatf("blue got %0d want %0d", got_px.blue, want.px.blue));
        if (m_axis_tlast !== want.last)
          flag_mismatch($sformatf("tlast got %b want %b", m_axis_tlast, want.last));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    int g;
    if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      g = pick_gap(sink_calm);
      if (g == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        sink_stall = g - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_corner_values();
    test_frame_restart();
    test_zero_sizes();
    test_width_clamp();
    test_tallest_frame();
    test_random_frames();
    settle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/shrp_pkg.sv
rtl/shrp_front.sv
rtl/shrp_queue.sv
rtl/shrp_back.sv
rtl/sharpen_3x3_rgb_filter.sv
tb/tb_top.sv
